/* hdl/stc_pkg.sv */
// ----------------------------------------------------------------------------
// stc_pkg
// shared types and constants of the split text console
// ----------------------------------------------------------------------------
`default_nettype none

package stc_pkg;

   localparam int ROWS_DEF    = 25;
   localparam int COLS_DEF    = 80;
   localparam int WINDOWS_DEF = 4;
   localparam int SEP_DEF     = 4;

   localparam logic [7:0] BLANK_CHAR       = 8'h20;
   localparam logic [7:0] BLANK_COLOUR_RST = 8'd7;
   localparam logic [7:0] SEP_CHAR_RST     = 8'd124;

   localparam logic [1:0] CSR_BLANK_COLOUR = 2'd0;
   localparam logic [1:0] CSR_SEP_CHAR     = 2'd1;

   typedef enum logic [2:0] {
      OP_RESERVE,
      OP_START,
      OP_SELECT,
      OP_PUT,
      OP_NEWLINE,
      OP_BACKSPACE,
      OP_CLEAR,
      OP_READ
   } op_type;

   // classified request as it travels from the front to the back
   typedef struct packed {
      op_type      op;
      logic [2:0]  screen;
      logic        screen_ok;
      logic [7:0]  char_code;
      logic [7:0]  colour;
      logic [4:0]  read_row;
      logic [6:0]  read_col;
      logic        read_ok;
   } req_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_FILL,
      ST_SEP,
      ST_CLR,
      ST_PUT,
      ST_SCR_RD,
      ST_SCR_WR,
      ST_SCR_BLK,
      ST_RD,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

/* hdl/split_text_console.sv */
// reserve adds a width division by repeated subtraction, put writes a cell,
// a put that wraps on the last row scrolls the window up and blanks its last row,
// clear blanks the active window, first start sweeps the store and writes separators
// throughput: one request at a time through the cell store's single port
// reset: synchronous, clears window state; the cell store is blanked by the first start
// ----------------------------------------------------------------------------
// split_text_console
// text-cell frame store split side by side into windows
// ----------------------------------------------------------------------------
`default_nettype none

module split_text_console #(
   parameter int ROWS    = stc_pkg::ROWS_DEF,
   parameter int COLS    = stc_pkg::COLS_DEF,
   parameter int WINDOWS = stc_pkg::WINDOWS_DEF,
   parameter int SEP     = stc_pkg::SEP_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_func,
   input  wire logic [2:0]  req_screen,
   input  wire logic [7:0]  req_char_code,
   input  wire logic [7:0]  req_colour,
   input  wire logic [4:0]  req_read_row,
   input  wire logic [6:0]  req_read_col,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_ok,
   output logic [7:0]       rsp_cell_char,
   output logic [7:0]       rsp_cell_colour,
   output logic [4:0]       rsp_cursor_row,
   output logic [6:0]       rsp_cursor_col,
   output logic [2:0]       rsp_window_count,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);

   logic             q_valid, q_pop;
   stc_pkg::req_type q_item;
   logic [7:0]       blank_colour_ff, blank_colour_in;
   logic [7:0]       sep_char_ff, sep_char_in;

   assign csr_ready = 1'b1;

   always_comb begin
      blank_colour_in = blank_colour_ff;
      sep_char_in     = sep_char_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            stc_pkg::CSR_BLANK_COLOUR: blank_colour_in = csr_wdata;
            stc_pkg::CSR_SEP_CHAR:     sep_char_in     = csr_wdata;
            default: begin
               blank_colour_in = blank_colour_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blank_colour_ff <= stc_pkg::BLANK_COLOUR_RST;
         sep_char_ff     <= stc_pkg::SEP_CHAR_RST;
      end else begin
         blank_colour_ff <= blank_colour_in;
         sep_char_ff     <= sep_char_in;
      end
   end

   stc_front #(
      .ROWS    (ROWS),
      .COLS    (COLS),
      .WINDOWS (WINDOWS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_screen    (req_screen),
      .req_char_code (req_char_code),
      .req_colour    (req_colour),
      .req_read_row  (req_read_row),
      .req_read_col  (req_read_col),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop)
   );

   stc_back #(
      .ROWS    (ROWS),
      .COLS    (COLS),
      .WINDOWS (WINDOWS),
      .SEP     (SEP)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .blank_colour     (blank_colour_ff),
      .separator_char   (sep_char_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_ok           (rsp_ok),
      .rsp_cell_char    (rsp_cell_char),
      .rsp_cell_colour  (rsp_cell_colour),
      .rsp_cursor_row   (rsp_cursor_row),
      .rsp_cursor_col   (rsp_cursor_col),
      .rsp_window_count (rsp_window_count)
   );

endmodule

`default_nettype wire

/* hdl/stc_front.sv */
// ----------------------------------------------------------------------------
// stc_front
// accepts requests, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
`default_nettype none

module stc_front #(
   parameter int ROWS    = stc_pkg::ROWS_DEF,
   parameter int COLS    = stc_pkg::COLS_DEF,
   parameter int WINDOWS = stc_pkg::WINDOWS_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire logic [2:0]      req_func,
   input  wire logic [2:0]      req_screen,
   input  wire logic [7:0]      req_char_code,
   input  wire logic [7:0]      req_colour,
   input  wire logic [4:0]      req_read_row,
   input  wire logic [6:0]      req_read_col,
   output logic                 q_valid,
   output stc_pkg::req_type     q_item,
   input  wire logic            q_pop
);

   stc_pkg::req_type entry_ff [2];
   stc_pkg::req_type new_item;
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   assign req_stall = (count_ff == 2'd2);
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = entry_ff[rd_ptr_ff];
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && q_valid;

   always_comb begin
      new_item.op        = stc_pkg::op_type'(req_func);
      new_item.screen    = req_screen;
      new_item.screen_ok = (32'(req_screen) < WINDOWS);
      new_item.char_code = req_char_code;
      new_item.colour    = req_colour;
      new_item.read_row  = req_read_row;
      new_item.read_col  = req_read_col;
      new_item.read_ok   = (32'(req_read_row) < ROWS) && (32'(req_read_col) < COLS);
   end

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

/* hdl/stc_back.sv */
// ----------------------------------------------------------------------------
// stc_back
// carries out requests on the cell store and window state, one at a time
// ----------------------------------------------------------------------------
`default_nettype none

module stc_back #(
   parameter int ROWS    = stc_pkg::ROWS_DEF,
   parameter int COLS    = stc_pkg::COLS_DEF,
   parameter int WINDOWS = stc_pkg::WINDOWS_DEF,
   parameter int SEP     = stc_pkg::SEP_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire stc_pkg::req_type  q_item,
   output logic                   q_pop,
   input  wire logic [7:0]        blank_colour,
   input  wire logic [7:0]        separator_char,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_ok,
   output logic [7:0]             rsp_cell_char,
   output logic [7:0]             rsp_cell_colour,
   output logic [4:0]             rsp_cursor_row,
   output logic [6:0]             rsp_cursor_col,
   output logic [2:0]             rsp_window_count
);

   localparam int RW = $clog2(ROWS);
   localparam int CW = $clog2(COLS + 2);
   localparam int AW = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
   localparam int KW = $clog2(WINDOWS + 1);
   localparam int OW = $clog2(WINDOWS * (COLS + SEP) + 1);
   localparam int PW = OW + 1;
   localparam int AD = $clog2(ROWS * COLS);
   localparam int SW = $clog2(SEP + 1);

   // cell store, undefined until the first start sweeps it
   logic [15:0] mem [ROWS * COLS];
   logic [15:0] rd_data_ff;
   logic        mem_we, mem_re, mem_fill;
   logic [RW-1:0] mem_row;
   logic [PW-1:0] mem_col;
   logic [AD-1:0] mem_addr;
   logic [15:0]   mem_wdata;
   logic          mem_in_range;

   stc_pkg::state_type state_ff, state_in;

   logic [RW-1:0] win_row_ff [WINDOWS];
   logic [RW-1:0] win_row_in [WINDOWS];
   logic [CW-1:0] win_col_ff [WINDOWS];
   logic [CW-1:0] win_col_in [WINDOWS];
   logic          win_res_ff [WINDOWS];
   logic          win_res_in [WINDOWS];
   logic [OW-1:0] win_org_ff [WINDOWS];
   logic [OW-1:0] win_org_in [WINDOWS];

   logic [KW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] act_ff, act_in;
   logic [CW-1:0] ww_ff, ww_in;
   logic          started_ff, started_in;
   logic          ok_ff, ok_in;
   logic [7:0]    oc_ff, oc_in, oa_ff, oa_in;
   logic [RW-1:0] r_ff, r_in;
   logic [CW-1:0] c_ff, c_in;
   logic [AD-1:0] fill_ff, fill_in;
   logic [KW-1:0] j_ff, j_in;
   logic [SW-1:0] s_ff, s_in;
   logic [OW-1:0] base_ff, base_in;
   logic [CW-1:0] rem_ff, rem_in, div_ff, div_in, quo_ff, quo_in;
   logic          nl_ff, nl_in, multi_ff, multi_in;
   logic [7:0]    put_ch_ff, put_ch_in, put_at_ff, put_at_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_ok_ff;
   logic [7:0]    rsp_oc_ff, rsp_oa_ff;
   logic [4:0]    rsp_row_ff;
   logic [6:0]    rsp_col_ff;
   logic [2:0]    rsp_cnt_ff;
   logic          rsp_load;

   logic [RW-1:0] cur_row, bs_row;
   logic [CW-1:0] cur_col, bs_col, ncol;
   logic [OW-1:0] cur_org;
   logic [15:0]   blank_word;
   logic          text_ok, outer;

   assign cur_row    = win_row_ff[act_ff];
   assign cur_col    = win_col_ff[act_ff];
   assign cur_org    = win_org_ff[act_ff];
   assign blank_word = {blank_colour, stc_pkg::BLANK_CHAR};
   assign text_ok    = started_ff && (ww_ff != '0);
   assign outer      = (SEP >= 3) && ((s_ff == '0) || (32'(s_ff) == SEP - 1));
   assign ncol       = cur_col + CW'(1);
   assign bs_row     = (cur_col == '0) ? cur_row - RW'(1) : cur_row;
   assign bs_col     = (cur_col == '0) ? ww_ff - CW'(1) : cur_col - CW'(1);

   assign mem_in_range = (32'(mem_col) < COLS);
   assign mem_addr     = mem_fill ? fill_ff : AD'(32'(mem_row) * COLS + 32'(mem_col));

   always_comb begin
      state_in   = state_ff;
      win_row_in = win_row_ff;
      win_col_in = win_col_ff;
      win_res_in = win_res_ff;
      win_org_in = win_org_ff;
      cnt_in     = cnt_ff;
      act_in     = act_ff;
      ww_in      = ww_ff;
      started_in = started_ff;
      ok_in      = ok_ff;
      oc_in      = oc_ff;
      oa_in      = oa_ff;
      r_in       = r_ff;
      c_in       = c_ff;
      fill_in    = fill_ff;
      j_in       = j_ff;
      s_in       = s_ff;
      base_in    = base_ff;
      rem_in     = rem_ff;
      div_in     = div_ff;
      quo_in     = quo_ff;
      nl_in      = nl_ff;
      multi_in   = multi_ff;
      put_ch_in  = put_ch_ff;
      put_at_in  = put_at_ff;
      q_pop      = 1'b0;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_fill   = 1'b0;
      mem_row    = r_ff;
      mem_col    = PW'(cur_org) + PW'(c_ff);
      mem_wdata  = blank_word;
      rsp_load   = 1'b0;

      case (state_ff)
         stc_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               ok_in  = 1'b0;
               oc_in  = '0;
               oa_in  = '0;
               state_in = stc_pkg::ST_DONE;
               case (q_item.op)
                  stc_pkg::OP_RESERVE: begin
                     if (32'(cnt_ff) < WINDOWS && q_item.screen_ok &&
                         !win_res_ff[q_item.screen[AW-1:0]]) begin
                        act_in = cnt_ff[AW-1:0];
                        win_row_in[cnt_ff[AW-1:0]] = '0;
                        win_col_in[cnt_ff[AW-1:0]] = '0;
                        win_res_in[cnt_ff[AW-1:0]] = 1'b1;
                        cnt_in = cnt_ff + KW'(1);
                        ok_in  = 1'b1;
                        div_in = CW'(cnt_ff) + CW'(1);
                        rem_in = (COLS >= int'(cnt_ff) * SEP) ?
                                 CW'(COLS - int'(cnt_ff) * SEP) : '0;
                        quo_in = '0;
                        state_in = stc_pkg::ST_DIV;
                     end
                  end
                  stc_pkg::OP_START: begin
                     ok_in = 1'b1;
                     if (!started_ff) begin
                        fill_in  = '0;
                        state_in = stc_pkg::ST_FILL;
                     end else if (cnt_ff != '0) begin
                        act_in   = '0;
                        r_in     = '0;
                        c_in     = '0;
                        multi_in = 1'b1;
                        state_in = stc_pkg::ST_CLR;
                     end
                  end
                  stc_pkg::OP_SELECT: begin
                     if (q_item.screen_ok) begin
                        act_in = q_item.screen[AW-1:0];
                        ok_in  = 1'b1;
                     end
                  end
                  stc_pkg::OP_PUT: begin
                     if (text_ok) begin
                        ok_in     = 1'b1;
                        put_ch_in = q_item.char_code;
                        put_at_in = q_item.colour;
                        nl_in     = 1'b0;
                        state_in  = stc_pkg::ST_PUT;
                     end
                  end
                  stc_pkg::OP_NEWLINE: begin
                     if (text_ok) begin
                        ok_in     = 1'b1;
                        put_ch_in = stc_pkg::BLANK_CHAR;
                        put_at_in = blank_colour;
                        nl_in     = 1'b1;
                        state_in  = stc_pkg::ST_PUT;
                     end
                  end
                  stc_pkg::OP_BACKSPACE: begin
                     if (text_ok) begin
                        ok_in = 1'b1;
                        if (cur_row != '0 || cur_col != '0) begin
                           win_row_in[act_ff] = bs_row;
                           win_col_in[act_ff] = bs_col;
                           mem_row = bs_row;
                           mem_col = PW'(cur_org) + PW'(bs_col);
                           mem_we  = mem_in_range;
                        end
                     end
                  end
                  stc_pkg::OP_CLEAR: begin
                     if (text_ok && cnt_ff != '0) begin
                        ok_in    = 1'b1;
                        r_in     = '0;
                        c_in     = '0;
                        multi_in = 1'b0;
                        state_in = stc_pkg::ST_CLR;
                     end
                  end
                  stc_pkg::OP_READ: begin
                     if (q_item.read_ok) begin
                        ok_in    = 1'b1;
                        mem_row  = RW'(q_item.read_row);
                        mem_col  = PW'(q_item.read_col);
                        mem_re   = 1'b1;
                        state_in = stc_pkg::ST_RD;
                     end
                  end
                  default: begin
                     state_in = stc_pkg::ST_DONE;
                  end
               endcase
            end
         end

         // width by repeated subtraction
         stc_pkg::ST_DIV: begin
            if (rem_ff >= div_ff) begin
               rem_in = rem_ff - div_ff;
               quo_in = quo_ff + CW'(1);
            end else begin
               ww_in    = quo_ff;
               state_in = stc_pkg::ST_DONE;
            end
         end

         stc_pkg::ST_FILL: begin
            mem_fill = 1'b1;
            mem_we   = 1'b1;
            fill_in  = fill_ff + AD'(1);
            if (32'(fill_ff) == ROWS * COLS - 1) begin
               for (int i = 0; i < WINDOWS; i++) begin
                  if (i < int'(cnt_ff)) begin
                     win_org_in[i] = OW'(i * (int'(ww_ff) + SEP));
                  end
               end
               if (32'(cnt_ff) > 1) begin
                  j_in     = KW'(1);
                  s_in     = '0;
                  r_in     = '0;
                  base_in  = OW'(ww_ff);
                  state_in = stc_pkg::ST_SEP;
               end else begin
                  started_in = 1'b1;
                  state_in   = stc_pkg::ST_DONE;
               end
            end
         end

         stc_pkg::ST_SEP: begin
            mem_row   = r_ff;
            mem_col   = PW'(base_ff) + PW'(s_ff);
            mem_wdata = {blank_colour, outer ? stc_pkg::BLANK_CHAR : separator_char};
            mem_we    = mem_in_range;
            if (32'(s_ff) == SEP - 1) begin
               s_in = '0;
               if (32'(r_ff) == ROWS - 1) begin
                  r_in = '0;
                  if (j_ff == cnt_ff - KW'(1)) begin
                     started_in = 1'b1;
                     state_in   = stc_pkg::ST_DONE;
                  end else begin
                     j_in    = j_ff + KW'(1);
                     base_in = base_ff + OW'(ww_ff) + OW'(SEP);
                  end
               end else begin
                  r_in = r_ff + RW'(1);
               end
            end else begin
               s_in = s_ff + SW'(1);
            end
         end

         stc_pkg::ST_CLR: begin
            if (ww_ff != '0) begin
               mem_we = mem_in_range;
            end
            if (ww_ff == '0 || (c_ff == ww_ff - CW'(1) && 32'(r_ff) == ROWS - 1)) begin
               win_row_in[act_ff] = '0;
               win_col_in[act_ff] = '0;
               r_in = '0;
               c_in = '0;
               if (multi_ff && (32'(act_ff) + 1 < 32'(cnt_ff))) begin
                  act_in = act_ff + AW'(1);
               end else begin
                  state_in = stc_pkg::ST_DONE;
               end
            end else if (c_ff == ww_ff - CW'(1)) begin
               c_in = '0;
               r_in = r_ff + RW'(1);
            end else begin
               c_in = c_ff + CW'(1);
            end
         end

         stc_pkg::ST_PUT: begin
            mem_row   = cur_row;
            mem_col   = PW'(cur_org) + PW'(cur_col);
            mem_wdata = {put_at_ff, put_ch_ff};
            mem_we    = mem_in_range;
            if (ncol >= ww_ff) begin
               win_col_in[act_ff] = '0;
               if (32'(cur_row) >= ROWS - 1) begin
                  r_in     = '0;
                  c_in     = '0;
                  state_in = stc_pkg::ST_SCR_RD;
               end else begin
                  win_row_in[act_ff] = cur_row + RW'(1);
                  state_in = stc_pkg::ST_DONE;
               end
            end else begin
               win_col_in[act_ff] = ncol;
               // newline keeps padding until the row wraps
               if (!nl_ff) begin
                  state_in = stc_pkg::ST_DONE;
               end
            end
         end

         stc_pkg::ST_SCR_RD: begin
            mem_row  = r_ff + RW'(1);
            mem_re   = mem_in_range;
            state_in = stc_pkg::ST_SCR_WR;
         end

         stc_pkg::ST_SCR_WR: begin
            mem_wdata = rd_data_ff;
            mem_we    = mem_in_range;
            state_in  = stc_pkg::ST_SCR_RD;
            if (c_ff == ww_ff - CW'(1)) begin
               c_in = '0;
               if (32'(r_ff) == ROWS - 2) begin
                  r_in     = RW'(ROWS - 1);
                  state_in = stc_pkg::ST_SCR_BLK;
               end else begin
                  r_in = r_ff + RW'(1);
               end
            end else begin
               c_in = c_ff + CW'(1);
            end
         end

         stc_pkg::ST_SCR_BLK: begin
            mem_we = mem_in_range;
            if (c_ff == ww_ff - CW'(1)) begin
               state_in = stc_pkg::ST_DONE;
            end else begin
               c_in = c_ff + CW'(1);
            end
         end

         stc_pkg::ST_RD: begin
            oc_in    = rd_data_ff[7:0];
            oa_in    = rd_data_ff[15:8];
            state_in = stc_pkg::ST_DONE;
         end

         stc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = stc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = stc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stc_pkg::ST_IDLE;
         cnt_ff       <= '0;
         act_ff       <= '0;
         ww_ff        <= '0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WINDOWS; i++) begin
            win_row_ff[i] <= '0;
            win_col_ff[i] <= '0;
            win_res_ff[i] <= 1'b0;
            win_org_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         act_ff       <= act_in;
         ww_ff        <= ww_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
         win_row_ff   <= win_row_in;
         win_col_ff   <= win_col_in;
         win_res_ff   <= win_res_in;
         win_org_ff   <= win_org_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff     <= ok_in;
      oc_ff     <= oc_in;
      oa_ff     <= oa_in;
      r_ff      <= r_in;
      c_ff      <= c_in;
      fill_ff   <= fill_in;
      j_ff      <= j_in;
      s_ff      <= s_in;
      base_ff   <= base_in;
      rem_ff    <= rem_in;
      div_ff    <= div_in;
      quo_ff    <= quo_in;
      nl_ff     <= nl_in;
      multi_ff  <= multi_in;
      put_ch_ff <= put_ch_in;
      put_at_ff <= put_at_in;
      if (rsp_load) begin
         rsp_ok_ff  <= ok_ff;
         rsp_oc_ff  <= oc_ff;
         rsp_oa_ff  <= oa_ff;
         rsp_row_ff <= 5'(cur_row);
         rsp_col_ff <= 7'(cur_col);
         rsp_cnt_ff <= 3'(cnt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_cell_char    = rsp_oc_ff;
   assign rsp_cell_colour  = rsp_oa_ff;
   assign rsp_cursor_row   = rsp_row_ff;
   assign rsp_cursor_col   = rsp_col_ff;
   assign rsp_window_count = rsp_cnt_ff;

   // a refused request never carries cell data
   a_refused_no_cell: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> (rsp_oc_ff == '0) && (rsp_oa_ff == '0))
      else $error("refused request returned cell data");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= WINDOWS)
      else $error("reserved window count beyond limit");

   a_started_sticky: assert property (@(posedge clock) disable iff (reset)
      started_ff |=> started_ff)
      else $error("started flag dropped");

   a_put_needs_width: assert property (@(posedge clock) disable iff (reset)
      (state_ff == stc_pkg::ST_PUT || state_ff == stc_pkg::ST_SCR_RD) |-> ww_ff != '0)
      else $error("cell write walk with zero window width");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == stc_pkg::ST_IDLE && q_valid)
      else $error("queue popped while busy");

endmodule

`default_nettype wire

/* dv/tb_split_text_console.sv */
// ----------------------------------------------------------------------------
// tb_split_text_console
// Self-checking bench for the split text console. A queue of requests feeds
// a clocked driver. A clocked monitor predicts each accepted request from a
// local copy of the cell store and window state, then checks every response
// field against the oldest prediction. Both sides idle at random, and the
// response side holds off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_split_text_console;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROWS  = stc_pkg::ROWS_DEF;
   localparam int COLS  = stc_pkg::COLS_DEF;
   localparam int WIN   = stc_pkg::WINDOWS_DEF;
   localparam int SEP   = stc_pkg::SEP_DEF;
   localparam int LIMIT = 10_000_000;

   typedef struct {
      stc_pkg::op_type op;
      logic [2:0]      scr;
      logic [7:0]      ch;
      logic [7:0]      at;
      logic [4:0]      rr;
      logic [6:0]      rc;
   } console_req_type;

   typedef struct {
      logic       ok;
      logic [7:0] ch;
      logic [7:0] at;
      logic [4:0] row;
      logic [6:0] col;
      logic [2:0] cnt;
   } console_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_func = '0;
   logic [2:0] req_screen = '0;
   logic [7:0] req_char_code = '0;
   logic [7:0] req_colour = '0;
   logic [4:0] req_read_row = '0;
   logic [6:0] req_read_col = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_ok;
   logic [7:0] rsp_cell_char;
   logic [7:0] rsp_cell_colour;
   logic [4:0] rsp_cursor_row;
   logic [6:0] rsp_cursor_col;
   logic [2:0] rsp_window_count;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;

   split_text_console i_dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_func, .req_screen, .req_char_code,
      .req_colour, .req_read_row, .req_read_col,
      .rsp_valid, .rsp_stall, .rsp_ok, .rsp_cell_char, .rsp_cell_colour,
      .rsp_cursor_row, .rsp_cursor_col, .rsp_window_count,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   always #6 clock = ~clock;

   // local copy of the console
   logic [15:0] cells [ROWS][COLS];
   int          cur_row [WIN];
   int          cur_col [WIN];
   int          origin [WIN];
   bit          taken [WIN];
   int          n_windows = 0;
   int          active = 0;
   int          width = 0;
   bit          started = 0;
   logic [7:0]  blank_attr = stc_pkg::BLANK_COLOUR_RST;
   logic [7:0]  sep_glyph = stc_pkg::SEP_CHAR_RST;

   console_req_type pending [$];
   console_rsp_type awaited [$];
   console_req_type cur_req;
   int           n_queued = 0;
   int           n_taken = 0;
   int           errors = 0;
   int           cycles = 0;
   int           req_gap = 0;
   int           rsp_wait = 0;
   int           hold_left = 0;
   bit           hold_used = 0;
   bit           req_taken = 0;
   bit           calm = 1;

   initial begin
      foreach (cells[r, c]) cells[r][c] = '0;
      foreach (taken[i]) begin
         taken[i] = 0; cur_row[i] = 0; cur_col[i] = 0; origin[i] = 0;
      end
   end

   function automatic void write_cell(int r, int c, logic [7:0] ch, logic [7:0] at);
      if (r < ROWS && c < COLS) cells[r][c] = {at, ch};
   endfunction

   function automatic void scroll_window(int w);
      for (int r = 0; r + 1 < ROWS; r++)
         for (int c = 0; c < width; c++)
            if (origin[w] + c < COLS) cells[r][origin[w] + c] = cells[r + 1][origin[w] + c];
      for (int c = 0; c < width; c++)
         write_cell(ROWS - 1, origin[w] + c, stc_pkg::BLANK_CHAR, blank_attr);
      cur_col[w] = 0;
   endfunction

   function automatic void put_glyph(logic [7:0] ch, logic [7:0] at);
      int w = active;
      write_cell(cur_row[w], origin[w] + cur_col[w], ch, at);
      cur_col[w]++;
      if (cur_col[w] >= width) begin
         if (cur_row[w] >= ROWS - 1) scroll_window(w);
         else begin
            cur_row[w]++;
            cur_col[w] = 0;
         end
      end
   endfunction

   function automatic void blank_window();
      for (int r = 0; r < ROWS; r++)
         for (int c = 0; c < width; c++)
            write_cell(r, origin[active] + c, stc_pkg::BLANK_CHAR, blank_attr);
      cur_row[active] = 0;
      cur_col[active] = 0;
   endfunction

   function automatic void open_console();
      int base;
      foreach (cells[r, c]) cells[r][c] = {blank_attr, stc_pkg::BLANK_CHAR};
      for (int i = 0; i < n_windows; i++) origin[i] = i * (width + SEP);
      for (int r = 0; r < ROWS; r++)
         for (int j = 1; j < n_windows; j++) begin
            base = j * width + (j - 1) * SEP;
            for (int s = 0; s < SEP; s++)
               write_cell(r, base + s,
                          (SEP >= 3 && (s == 0 || s == SEP - 1)) ?
                          stc_pkg::BLANK_CHAR : sep_glyph,
                          blank_attr);
         end
      started = 1;
   endfunction

   function automatic console_rsp_type console_step(console_req_type q);
      console_rsp_type o;
      bit text_ok = started && width != 0;
      int k, n;
      o = '{default: '0};
      case (q.op)
         stc_pkg::OP_RESERVE:
            if (n_windows < WIN && q.scr < WIN && !taken[q.scr]) begin
               k = n_windows;
               width = (COLS >= k * SEP) ? (COLS - k * SEP) / (k + 1) : 0;
               active = k;
               cur_row[k] = 0;
               cur_col[k] = 0;
               taken[k] = 1;
               n_windows = k + 1;
               o.ok = 1;
            end
         stc_pkg::OP_START: begin
            if (!started) open_console();
            else
               for (int i = 0; i < n_windows; i++) begin
                  active = i;
                  blank_window();
               end
            o.ok = 1;
         end
         stc_pkg::OP_SELECT:
            if (q.scr < WIN) begin
               active = int'(q.scr);
               o.ok = 1;
            end
         stc_pkg::OP_PUT:
            if (text_ok) begin
               put_glyph(q.ch, q.at);
               o.ok = 1;
            end
         stc_pkg::OP_NEWLINE:
            if (text_ok) begin
               // a cursor past a narrowed width only wraps
               n = (cur_col[active] < width) ? width - cur_col[active] : 1;
               repeat (n) put_glyph(stc_pkg::BLANK_CHAR, blank_attr);
               o.ok = 1;
            end
         stc_pkg::OP_BACKSPACE:
            if (text_ok) begin
               if (cur_row[active] != 0 || cur_col[active] != 0) begin
                  if (cur_col[active] == 0) begin
                     cur_row[active]--;
                     cur_col[active] = width - 1;
                  end else cur_col[active]--;
                  write_cell(cur_row[active], origin[active] + cur_col[active],
                             stc_pkg::BLANK_CHAR, blank_attr);
               end
               o.ok = 1;
            end
         stc_pkg::OP_CLEAR:
            if (text_ok && n_windows != 0) begin
               blank_window();
               o.ok = 1;
            end
         default:
            if (q.rr < ROWS && q.rc < COLS) begin
               o.ch = cells[q.rr][q.rc][7:0];
               o.at = cells[q.rr][q.rc][15:8];
               o.ok = 1;
            end
      endcase
      o.row = cur_row[active][4:0];
      o.col = cur_col[active][6:0];
      o.cnt = n_windows[2:0];
      return o;
   endfunction

   task automatic report(string what, int got, int want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
      errors++;
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) req_valid <= 1'b0;
      else if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending.size() > 0) begin
            cur_req = pending.pop_front();
            req_func      <= cur_req.op;
            req_screen    <= cur_req.scr;
            req_char_code <= cur_req.ch;
            req_colour    <= cur_req.at;
            req_read_row  <= cur_req.rr;
            req_read_col  <= cur_req.rc;
            req_valid     <= 1'b1;
            req_gap = calm ? 0 : int'($urandom_range(0, 5));
         end else req_valid <= 1'b0;
      end
   end

   // long hold-off on the response side so the block backs up
   always @(negedge clock) begin
      if (!hold_used && n_taken >= 40) begin
         hold_used <= 1;
         hold_left <= 400;
      end else if (hold_left > 0) hold_left <= hold_left - 1;
   end

   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if (hold_left != 0) rsp_stall <= 1'b1;
      else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_stall <= 1'b1;
      end else rsp_stall <= 1'b0;
   end

   // monitor
   always @(posedge clock) begin
      console_req_type q;
      console_rsp_type e;
      cycles++;
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) begin
         q.op = stc_pkg::op_type'(req_func);
         q.scr = req_screen;
         q.ch = req_char_code;
         q.at = req_colour;
         q.rr = req_read_row;
         q.rc = req_read_col;
         awaited.push_back(console_step(q));
         n_taken++;
         if ($urandom_range(0, 63) == 0) calm = !calm;
      end
      if (!reset && csr_valid && csr_ready) begin
         if (csr_index == stc_pkg::CSR_BLANK_COLOUR) blank_attr = csr_wdata;
         else if (csr_index == stc_pkg::CSR_SEP_CHAR) sep_glyph = csr_wdata;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited.size() == 0) report("response with nothing awaited", 1, 0);
         else begin
            e = awaited.pop_front();
            if (rsp_ok !== e.ok) report("ok", int'(rsp_ok), int'(e.ok));
            if (rsp_cell_char !== e.ch)
               report("cell_char", int'(rsp_cell_char), int'(e.ch));
            if (rsp_cell_colour !== e.at)
               report("cell_colour", int'(rsp_cell_colour), int'(e.at));
            if (rsp_cursor_row !== e.row)
               report("cursor_row", int'(rsp_cursor_row), int'(e.row));
            if (rsp_cursor_col !== e.col)
               report("cursor_col", int'(rsp_cursor_col), int'(e.col));
            if (rsp_window_count !== e.cnt)
               report("window_count", int'(rsp_window_count), int'(e.cnt));
         end
         rsp_wait = calm ? 0 : int'($urandom_range(0, 5));
      end
      if (cycles > LIMIT) begin
         $display("FAIL split_text_console");
         $finish;
      end
   end

   // -1 leaves a field random; reads land in range most of the time
   function automatic void add(stc_pkg::op_type op, int scr = -1, int rr = -1, int rc = -1,
                               int ch = -1, int at = -1);
      console_req_type q;
      bit wide = ($urandom_range(0, 9) == 0);
      q.op  = op;
      q.scr = (scr < 0) ? 3'($urandom_range(0, 7)) : 3'(scr);
      q.ch  = (ch < 0) ? 8'($urandom_range(0, 255)) : 8'(ch);
      q.at  = (at < 0) ? 8'($urandom_range(0, 255)) : 8'(at);
      q.rr  = (rr >= 0) ? 5'(rr) :
              wide ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, ROWS - 1));
      q.rc  = (rc >= 0) ? 7'(rc) :
              wide ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, COLS - 1));
      pending.push_back(q);
      n_queued++;
   endfunction

   task automatic write_reg(logic [1:0] idx, logic [7:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      wait (n_taken == n_queued && awaited.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   // bursts of text on one window reach wrap and scroll; the rest is noise
   task automatic random_phase(int count);
      int left = count;
      int len, k;
      while (left > 0) begin
         if ($urandom_range(0, 9) < 8) begin
            add(stc_pkg::OP_SELECT, int'($urandom_range(0, WIN - 1)));
            len = int'($urandom_range(5, 40));
            repeat (len) begin
               k = int'($urandom_range(0, 99));
               if (k < 45) add(stc_pkg::OP_NEWLINE);
               else if (k < 80) add(stc_pkg::OP_PUT);
               else if (k < 88) add(stc_pkg::OP_BACKSPACE);
               else add(stc_pkg::OP_READ);
            end
            left -= len + 1;
         end else begin
            add(stc_pkg::op_type'(3'($urandom_range(0, 7))));
            left--;
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_reg(stc_pkg::CSR_BLANK_COLOUR, 8'h00);
      write_reg(stc_pkg::CSR_SEP_CHAR, 8'hff);

      // text is refused before the first start
      add(stc_pkg::OP_PUT);
      add(stc_pkg::OP_NEWLINE);
      add(stc_pkg::OP_BACKSPACE);
      add(stc_pkg::OP_CLEAR);
      add(stc_pkg::OP_READ, -1, 31, 127);
      // reserve marks the next free slot, not the one asked for
      add(stc_pkg::OP_RESERVE, 7);
      add(stc_pkg::OP_RESERVE, 1);
      add(stc_pkg::OP_RESERVE, 1);
      add(stc_pkg::OP_RESERVE, 0);
      add(stc_pkg::OP_RESERVE, 2);
      add(stc_pkg::OP_START);
      add(stc_pkg::OP_SELECT, 3);
      add(stc_pkg::OP_SELECT, 5);
      add(stc_pkg::OP_PUT, -1, -1, -1, 0, 0);
      add(stc_pkg::OP_PUT, -1, -1, -1, 255, 255);
      add(stc_pkg::OP_SELECT, 1);
      add(stc_pkg::OP_BACKSPACE);
      add(stc_pkg::OP_NEWLINE);
      add(stc_pkg::OP_BACKSPACE);
      add(stc_pkg::OP_READ, -1, 0, 24);
      add(stc_pkg::OP_READ, -1, 0, 25);
      add(stc_pkg::OP_READ, -1, 24, 79);
      add(stc_pkg::OP_READ, -1, 25, 0);
      add(stc_pkg::OP_READ, -1, 0, 80);
      // leave the cursor past the width that the next reserve will give
      add(stc_pkg::OP_SELECT, 2);
      repeat (18) add(stc_pkg::OP_PUT);
      add(stc_pkg::OP_RESERVE, 3);
      add(stc_pkg::OP_RESERVE, 0);
      add(stc_pkg::OP_SELECT, 2);
      add(stc_pkg::OP_NEWLINE);
      add(stc_pkg::OP_CLEAR);
      add(stc_pkg::OP_START);
      drain();

      write_reg(stc_pkg::CSR_BLANK_COLOUR, 8'hff);
      write_reg(stc_pkg::CSR_SEP_CHAR, 8'h00);
      random_phase(150);
      drain();

      write_reg(stc_pkg::CSR_BLANK_COLOUR, 8'($urandom_range(0, 255)));
      write_reg(stc_pkg::CSR_SEP_CHAR, 8'($urandom_range(0, 255)));
      random_phase(150);
      drain();

      if (errors == 0) $display("PASS split_text_console");
      else $display("FAIL split_text_console");
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
hdl/stc_pkg.sv
hdl/stc_front.sv
hdl/stc_back.sv
hdl/split_text_console.sv
dv/tb_split_text_console.sv
